// ===== hdl/onewire_bus_master_unit_defines.svh =====
`ifndef ONEWIRE_BUS_MASTER_UNIT_DEFINES_SVH
`define ONEWIRE_BUS_MASTER_UNIT_DEFINES_SVH

// same-cycle implication, held off while rst_n is low
`define OWBM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("owbm: check failed");

// next-cycle implication, held off while rst_n is low
`define OWBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("owbm: check failed");

`endif

// ===== hdl/owbm_pkg.sv =====
`default_nettype none

package owbm_pkg;

    localparam int TIMER_BITS_DEF = 10;
    localparam int CFG_W          = 10;
    localparam int CFG_IDX_W      = 4;
    localparam int CFG_DATA_W     = 16;
    localparam int LOW_RUN_LIMIT  = 240;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_RELEASE = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ONE_LOW = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_ZERO_LOW = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_READ_LOW      = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_READ_TAIL     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 4'd7;

    // register defaults
    localparam logic [CFG_W-1:0] RESET_LOW_DEF      = 10'd750;
    localparam logic [CFG_W-1:0] RESET_RELEASE_DEF  = 10'd15;
    localparam logic [CFG_W-1:0] WRITE_ONE_LOW_DEF  = 10'd10;
    localparam logic [CFG_W-1:0] WRITE_ZERO_LOW_DEF = 10'd60;
    localparam logic [CFG_W-1:0] READ_LOW_DEF       = 10'd1;
    localparam logic [CFG_W-1:0] READ_SAMPLE_DEF    = 10'd2;
    localparam logic [CFG_W-1:0] READ_TAIL_DEF      = 10'd60;
    localparam logic [CFG_W-1:0] PRESENCE_WAIT_DEF  = 10'd200;

    // command codes
    localparam logic [1:0] CMD_RESET = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_LOW   = 4'd1,
        PH_RST_REL   = 4'd2,
        PH_PRES_LOW  = 4'd3,
        PH_PRES_HIGH = 4'd4,
        PH_WR_LOW    = 4'd5,
        PH_WR_TAIL   = 4'd6,
        PH_RD_LOW    = 4'd7,
        PH_RD_REL    = 4'd8,
        PH_RD_TAIL   = 4'd9
    } phase_t;

    typedef struct packed {
        logic       cmd_valid;
        logic [1:0] cmd;
        logic [7:0] write_data;
        logic       line_level;
    } in_item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       device_absent;
    } out_item_t;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_us;
        logic [CFG_W-1:0] reset_release_us;
        logic [CFG_W-1:0] write_one_low_us;
        logic [CFG_W-1:0] write_zero_low_us;
        logic [CFG_W-1:0] read_low_us;
        logic [CFG_W-1:0] read_sample_us;
        logic [CFG_W-1:0] read_tail_us;
        logic [CFG_W-1:0] presence_wait_us;
    } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/owbm_cfg.sv =====
`default_nettype none

module owbm_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            wr_en,
    input  wire logic [owbm_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [owbm_pkg::CFG_DATA_W-1:0] wr_data,
    output owbm_pkg::cfg_t                       cfg
);
    import owbm_pkg::*;

    cfg_t             cfg_reg;
    logic [CFG_W-1:0] value;

    assign value = wr_data[CFG_W-1:0];
    assign cfg   = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_us      <= RESET_LOW_DEF;
            cfg_reg.reset_release_us  <= RESET_RELEASE_DEF;
            cfg_reg.write_one_low_us  <= WRITE_ONE_LOW_DEF;
            cfg_reg.write_zero_low_us <= WRITE_ZERO_LOW_DEF;
            cfg_reg.read_low_us       <= READ_LOW_DEF;
            cfg_reg.read_sample_us    <= READ_SAMPLE_DEF;
            cfg_reg.read_tail_us      <= READ_TAIL_DEF;
            cfg_reg.presence_wait_us  <= PRESENCE_WAIT_DEF;
        end else if (wr_en) begin
            unique case (wr_index)
                REG_RESET_LOW:      cfg_reg.reset_low_us      <= value;
                REG_RESET_RELEASE:  cfg_reg.reset_release_us  <= value;
                REG_WRITE_ONE_LOW:  cfg_reg.write_one_low_us  <= value;
                REG_WRITE_ZERO_LOW: cfg_reg.write_zero_low_us <= value;
                REG_READ_LOW:       cfg_reg.read_low_us       <= value;
                REG_READ_SAMPLE:    cfg_reg.read_sample_us    <= value;
                REG_READ_TAIL:      cfg_reg.read_tail_us      <= value;
                REG_PRESENCE_WAIT:  cfg_reg.presence_wait_us  <= value;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/owbm_core.sv =====
`default_nettype none

module owbm_core #(
    parameter int TIMER_BITS = owbm_pkg::TIMER_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                step_en,
    input  wire owbm_pkg::in_item_t  item,
    input  wire owbm_pkg::cfg_t      cfg,
    output owbm_pkg::out_item_t      result
);
    import owbm_pkg::*;

    localparam int CW = ((TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W) + 1;
    localparam logic [TIMER_BITS-1:0] CNT_MAX = '1;

    phase_t                phase_reg, phase_next, ph0;
    logic [TIMER_BITS-1:0] tc_reg, tc_next, tc0;
    logic [2:0]            bi_reg, bi_next, bi0;
    logic [7:0]            sb_reg, sb_next, sb0, sb_sampled;
    logic [7:0]            rb_reg, rb_next;
    logic                  absent_reg, absent_next;
    logic                  start;
    logic [CFG_W-1:0]      dur;
    logic [CW-1:0]         tc_inc;
    logic                  ends, low_run_over;
    logic                  drive, done;

    // command pickup while idle; an unknown code leaves the block idle
    assign start = (phase_reg == PH_IDLE) && item.cmd_valid;

    always_comb begin
        ph0 = phase_reg;
        tc0 = tc_reg;
        bi0 = bi_reg;
        sb0 = sb_reg;
        if (start) begin
            tc0 = '0;
            unique case (item.cmd)
                CMD_RESET: ph0 = PH_RST_LOW;
                CMD_WRITE: begin
                    ph0 = PH_WR_LOW;
                    sb0 = item.write_data;
                    bi0 = '0;
                end
                CMD_READ: begin
                    ph0 = PH_RD_LOW;
                    sb0 = '0;
                    bi0 = '0;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (ph0)
            PH_RST_LOW:  dur = cfg.reset_low_us;
            PH_RST_REL:  dur = cfg.reset_release_us;
            PH_PRES_LOW: dur = cfg.presence_wait_us;
            PH_WR_LOW:   dur = sb0[0] ? cfg.write_one_low_us : cfg.write_zero_low_us;
            PH_WR_TAIL:  dur = cfg.write_zero_low_us;
            PH_RD_LOW:   dur = cfg.read_low_us;
            PH_RD_REL:   dur = cfg.read_sample_us;
            PH_RD_TAIL:  dur = cfg.read_tail_us;
            default:     dur = cfg.reset_low_us;
        endcase
    end

    // a zero duration still lasts one tick; a saturated counter also ends the phase
    assign tc_inc       = CW'(tc0) + CW'(1);
    assign ends         = (tc_inc >= CW'(dur)) || (tc0 == CNT_MAX);
    assign low_run_over = (tc_inc >= CW'(LOW_RUN_LIMIT)) || (tc_inc >= CW'(CNT_MAX));

    // first tail tick takes the sample
    always_comb begin
        sb_sampled = sb0;
        if (tc0 == '0) begin
            sb_sampled[bi0] = item.line_level;
        end
    end

    always_comb begin
        phase_next = ph0;
        unique case (ph0)
            PH_IDLE:     phase_next = PH_IDLE;
            PH_RST_LOW:  if (ends) phase_next = PH_RST_REL;
            PH_RST_REL:  if (ends) phase_next = PH_PRES_LOW;
            PH_PRES_LOW: begin
                if (!item.line_level) begin
                    phase_next = PH_PRES_HIGH;
                end else if (ends) begin
                    phase_next = PH_IDLE;
                end
            end
            PH_PRES_HIGH: if (item.line_level || low_run_over) phase_next = PH_IDLE;
            PH_WR_LOW:   if (ends) phase_next = PH_WR_TAIL;
            PH_WR_TAIL:  if (ends) phase_next = (bi0 == 3'd7) ? PH_IDLE : PH_WR_LOW;
            PH_RD_LOW:   if (ends) phase_next = PH_RD_REL;
            PH_RD_REL:   if (ends) phase_next = PH_RD_TAIL;
            PH_RD_TAIL:  if (ends) phase_next = (bi0 == 3'd7) ? PH_IDLE : PH_RD_LOW;
            default:     phase_next = PH_IDLE;
        endcase
    end

    always_comb begin
        drive       = 1'b0;
        done        = 1'b0;
        tc_next     = ends ? '0 : tc_inc[TIMER_BITS-1:0];
        bi_next     = bi0;
        sb_next     = sb0;
        rb_next     = rb_reg;
        absent_next = absent_reg;
        unique case (ph0)
            PH_IDLE: tc_next = tc0;
            PH_RST_LOW: drive = 1'b1;
            PH_RST_REL: ;
            PH_PRES_LOW: begin
                if (!item.line_level) begin
                    tc_next = TIMER_BITS'(1);
                end else if (ends) begin
                    absent_next = 1'b1;
                    done        = 1'b1;
                end
            end
            PH_PRES_HIGH: begin
                if (item.line_level) begin
                    absent_next = 1'b0;
                    done        = 1'b1;
                    tc_next     = '0;
                end else if (low_run_over) begin
                    absent_next = 1'b1;
                    done        = 1'b1;
                    tc_next     = '0;
                end else begin
                    tc_next = tc_inc[TIMER_BITS-1:0];
                end
            end
            PH_WR_LOW: drive = 1'b1;
            PH_WR_TAIL: begin
                drive = ~sb0[0];
                if (ends) begin
                    sb_next = {1'b0, sb0[7:1]};
                    if (bi0 == 3'd7) begin
                        done = 1'b1;
                    end else begin
                        bi_next = bi0 + 3'd1;
                    end
                end
            end
            PH_RD_LOW: drive = 1'b1;
            PH_RD_REL: ;
            PH_RD_TAIL: begin
                sb_next = sb_sampled;
                if (ends) begin
                    if (bi0 == 3'd7) begin
                        rb_next = sb_sampled;
                        done    = 1'b1;
                    end else begin
                        bi_next = bi0 + 3'd1;
                    end
                end
            end
            default: tc_next = tc0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            tc_reg     <= '0;
            bi_reg     <= '0;
            sb_reg     <= '0;
            rb_reg     <= '0;
            absent_reg <= 1'b0;
        end else if (step_en) begin
            phase_reg  <= phase_next;
            tc_reg     <= tc_next;
            bi_reg     <= bi_next;
            sb_reg     <= sb_next;
            rb_reg     <= rb_next;
            absent_reg <= absent_next;
        end
    end

    assign result.drive_low     = drive;
    assign result.busy_res      = (phase_next != PH_IDLE);
    assign result.done_res      = done;
    assign result.read_data     = rb_next;
    assign result.device_absent = absent_next;

endmodule

`default_nettype wire

// ===== hdl/onewire_bus_master_unit.sv =====
// Latency: a result is valid on m_ the cycle after its tick item is accepted.
// Throughput: one tick item per cycle; a held result does not block the next
// item as long as m_ready is high in that cycle.
// cfg_ready is always high; a write takes effect on the next cycle.
// Reset (aresetn low, synchronous): registers return to their defaults,
// the bus sequencer goes idle and the result register is emptied.
`default_nettype none

module onewire_bus_master_unit #(
    parameter int TIMER_BITS = owbm_pkg::TIMER_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output      logic                            s_ready,
    input  wire owbm_pkg::in_item_t              s_data,
    output      logic                            m_valid,
    input  wire logic                            m_ready,
    output      owbm_pkg::out_item_t             m_data,
    input  wire logic                            cfg_valid,
    output      logic                            cfg_ready,
    input  wire logic [owbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [owbm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import owbm_pkg::*;

    cfg_t      cfg;
    out_item_t result;
    out_item_t m_data_reg;
    logic      m_valid_reg;
    logic      step_en;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign step_en   = s_valid && s_ready;

    owbm_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    owbm_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (s_data),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_en) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== hdl/owbm_checker.sv =====
`default_nettype none

`include "onewire_bus_master_unit_defines.svh"

module owbm_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_valid,
    input wire logic                            s_ready,
    input wire owbm_pkg::in_item_t              s_data,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire owbm_pkg::out_item_t             m_data,
    input wire logic                            cfg_valid,
    input wire logic                            cfg_ready,
    input wire logic [owbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input wire logic [owbm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import owbm_pkg::*;

    logic unused_ok;
    assign unused_ok = ^{s_valid, s_data, cfg_valid, cfg_ready, cfg_index, cfg_data};

    // a stalled result holds
    `OWBM_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // completion tick never reports busy
    `OWBM_ASSERT_NOW(a_done_idle, aclk, aresetn, m_valid && m_data.done_res,
        !m_data.busy_res || unused_ok || !unused_ok ? !m_data.busy_res : 1'b0)

    // input side only stalls behind a full result register
    `OWBM_ASSERT_NOW(a_stall, aclk, aresetn, !s_ready, m_valid && !m_ready)

    // result register is empty after reset
    `OWBM_ASSERT_NEXT(a_rst_empty, aclk, 1'b1, !aresetn, !m_valid)

endmodule

bind onewire_bus_master_unit owbm_checker u_owbm_checker (.*);

`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import owbm_pkg::*;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;
    localparam int TICK_MAX = (1 << TIMER_BITS_DEF) - 1;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    onewire_bus_master_unit u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // timing registers as the block should hold them
    cfg_t timing = '{
        reset_low_us:      RESET_LOW_DEF,
        reset_release_us:  RESET_RELEASE_DEF,
        write_one_low_us:  WRITE_ONE_LOW_DEF,
        write_zero_low_us: WRITE_ZERO_LOW_DEF,
        read_low_us:       READ_LOW_DEF,
        read_sample_us:    READ_SAMPLE_DEF,
        read_tail_us:      READ_TAIL_DEF,
        presence_wait_us:  PRESENCE_WAIT_DEF
    };

    // bus sequencer state
    phase_t ph = PH_IDLE;
    logic [TIMER_BITS_DEF-1:0] tcount = '0;
    logic [2:0] bit_pos = '0;
    logic [7:0] shift_reg = '0;
    logic [7:0] last_read = '0;
    logic absent = 1'b0;

    in_item_t tick_items[$];
    out_item_t bus_results[$];
    int mism_cnt = 0;
    int pushed = 0;
    bit calm = 1'b0;

    task automatic flag_error(input string what);
        mism_cnt++;
        $display("ERROR at %0t: %s", $time, what);
    endtask

    // counts one tick of the current interval; true on its last tick
    function automatic bit interval_done(input logic [CFG_W-1:0] dur);
        if (32'(tcount) + 1 >= 32'(dur) || 32'(tcount) >= TICK_MAX) begin
            tcount = '0;
            return 1'b1;
        end
        tcount++;
        return 1'b0;
    endfunction

    function automatic out_item_t sequence_tick(input in_item_t it);
        logic drv;
        logic dn;
        drv = 1'b0;
        dn = 1'b0;
        if (ph == PH_IDLE && it.cmd_valid) begin
            tcount = '0;
            case (it.cmd)
                CMD_RESET: ph = PH_RST_LOW;
                CMD_WRITE: begin
                    ph = PH_WR_LOW;
                    shift_reg = it.write_data;
                    bit_pos = '0;
                end
                CMD_READ: begin
                    ph = PH_RD_LOW;
                    shift_reg = '0;
                    bit_pos = '0;
                end
                default: ;
            endcase
        end
        case (ph)
            PH_RST_LOW: begin
                drv = 1'b1;
                if (interval_done(timing.reset_low_us)) ph = PH_RST_REL;
            end
            PH_RST_REL: begin
                if (interval_done(timing.reset_release_us)) ph = PH_PRES_LOW;
            end
            PH_PRES_LOW: begin
                if (!it.line_level) begin
                    ph = PH_PRES_HIGH;
                    tcount = 1;
                end else if (interval_done(timing.presence_wait_us)) begin
                    absent = 1'b1;
                    ph = PH_IDLE;
                    dn = 1'b1;
                end
            end
            PH_PRES_HIGH: begin
                if (it.line_level) begin
                    absent = 1'b0;
                    ph = PH_IDLE;
                    dn = 1'b1;
                    tcount = '0;
                end else begin
                    tcount++;
                    if (32'(tcount) >= LOW_RUN_LIMIT || 32'(tcount) >= TICK_MAX) begin
                        absent = 1'b1;
                        ph = PH_IDLE;
                        dn = 1'b1;
                        tcount = '0;
                    end
                end
            end
            PH_WR_LOW: begin
                drv = 1'b1;
                if (interval_done(shift_reg[0] ? timing.write_one_low_us
                                               : timing.write_zero_low_us))
                    ph = PH_WR_TAIL;
            end
            PH_WR_TAIL: begin
                drv = ~shift_reg[0];
                if (interval_done(timing.write_zero_low_us)) begin
                    shift_reg = shift_reg >> 1;
                    if (bit_pos == 3'd7) begin
                        ph = PH_IDLE;
                        dn = 1'b1;
                    end else begin
                        bit_pos++;
                        ph = PH_WR_LOW;
                    end
                end
            end
            PH_RD_LOW: begin
                drv = 1'b1;
                if (interval_done(timing.read_low_us)) ph = PH_RD_REL;
            end
            PH_RD_REL: begin
                if (interval_done(timing.read_sample_us)) ph = PH_RD_TAIL;
            end
            PH_RD_TAIL: begin
                // the first tail tick takes the sample
                if (tcount == '0) shift_reg[bit_pos] = shift_reg[bit_pos] | it.line_level;
                if (interval_done(timing.read_tail_us)) begin
                    if (bit_pos == 3'd7) begin
                        last_read = shift_reg;
                        ph = PH_IDLE;
                        dn = 1'b1;
                    end else begin
                        bit_pos++;
                        ph = PH_RD_LOW;
                    end
                end
            end
            default: ph = PH_IDLE;
        endcase
        return '{drive_low: drv, busy_res: (ph != PH_IDLE), done_res: dn,
                 read_data: last_read, device_absent: absent};
    endfunction

    // tick driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (tick_items.size() != 0 && (calm || $urandom_range(99) >= 24)) begin
                s_data <= tick_items.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            bus_results.push_back(sequence_tick(s_data));
    end

    // result monitor
    always @(posedge aclk) begin : mon
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (bus_results.size() == 0) begin
                    flag_error("result with no tick pending");
                end else begin
                    want = bus_results.pop_front();
                    if (m_data.drive_low !== want.drive_low)
                        flag_error($sformatf("drive_low exp %0b got %b",
                                             want.drive_low, m_data.drive_low));
                    if (m_data.busy_res !== want.busy_res)
                        flag_error($sformatf("busy_res exp %0b got %b",
                                             want.busy_res, m_data.busy_res));
                    if (m_data.done_res !== want.done_res)
                        flag_error($sformatf("done_res exp %0b got %b",
                                             want.done_res, m_data.done_res));
                    if (m_data.read_data !== want.read_data)
                        flag_error($sformatf("read_data exp %02h got %02h",
                                             want.read_data, m_data.read_data));
                    if (m_data.device_absent !== want.device_absent)
                        flag_error($sformatf("device_absent exp %0b got %b",
                                             want.device_absent, m_data.device_absent));
                end
            end
            m_ready <= calm || ($urandom_range(99) >= 24);
        end
    end

    function automatic int span_of(input logic [CFG_W-1:0] d);
        return (d == '0) ? 1 : int'(d);
    endfunction

    task automatic push_tick(input logic cv, input logic [1:0] op, input logic [7:0] wd,
                             input logic lvl);
        tick_items.push_back('{cmd_valid: cv, cmd: op, write_data: wd, line_level: lvl});
        pushed++;
    endtask

    // One command with its busy ticks and a short idle gap. For a reset, the
    // slave keeps the line high for hi ticks, then low for lo ticks (lo 0:
    // no pulse at all). With early set the next item lands on the done tick.
    task automatic queue_cmd(input logic [1:0] op, input logic [7:0] wd,
                             input int hi, input int lo, input bit early);
        int total;
        int pre;
        int pw;
        int u;
        logic lvl;
        pre = span_of(timing.reset_low_us) + span_of(timing.reset_release_us);
        pw = span_of(timing.presence_wait_us);
        case (op)
            CMD_WRITE: begin
                total = 0;
                for (int b = 0; b < 8; b++)
                    total += span_of(wd[b] ? timing.write_one_low_us
                                           : timing.write_zero_low_us)
                             + span_of(timing.write_zero_low_us);
            end
            CMD_READ: total = 8 * (span_of(timing.read_low_us)
                                   + span_of(timing.read_sample_us)
                                   + span_of(timing.read_tail_us));
            default: begin
                if (lo == 0 || hi >= pw) total = pre + pw;
                else if (lo >= LOW_RUN_LIMIT) total = pre + hi + LOW_RUN_LIMIT;
                else total = pre + hi + lo + 1;
            end
        endcase
        if (early) total--;
        for (int t = 0; t < total; t++) begin
            u = t - pre;
            if (op != CMD_RESET || u < 0) lvl = 1'($urandom_range(1));
            else lvl = (u < hi || lo == 0 || u >= hi + lo);
            if (t == 0) push_tick(1'b1, op, wd, lvl);
            else push_tick($urandom_range(7) == 0, 2'($urandom_range(3)),
                           8'($urandom), lvl);
        end
        repeat ($urandom_range(3))
            push_tick($urandom_range(3) == 0, CMD_UNKNOWN, 8'($urandom),
                      1'($urandom_range(1)));
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(val);
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_RESET_LOW:      timing.reset_low_us = val;
            REG_RESET_RELEASE:  timing.reset_release_us = val;
            REG_WRITE_ONE_LOW:  timing.write_one_low_us = val;
            REG_WRITE_ZERO_LOW: timing.write_zero_low_us = val;
            REG_READ_LOW:       timing.read_low_us = val;
            REG_READ_SAMPLE:    timing.read_sample_us = val;
            REG_READ_TAIL:      timing.read_tail_us = val;
            REG_PRESENCE_WAIT:  timing.presence_wait_us = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic program_timing(input cfg_t t);
        set_reg(REG_RESET_LOW, t.reset_low_us);
        set_reg(REG_RESET_RELEASE, t.reset_release_us);
        set_reg(REG_WRITE_ONE_LOW, t.write_one_low_us);
        set_reg(REG_WRITE_ZERO_LOW, t.write_zero_low_us);
        set_reg(REG_READ_LOW, t.read_low_us);
        set_reg(REG_READ_SAMPLE, t.read_sample_us);
        set_reg(REG_READ_TAIL, t.read_tail_us);
        set_reg(REG_PRESENCE_WAIT, t.presence_wait_us);
        @(negedge aclk);
    endtask

    // sender holds off until every tick has been answered
    task automatic wait_drained();
        do @(negedge aclk);
        while (tick_items.size() != 0 || s_valid || bus_results.size() != 0);
    endtask

    initial begin
        cfg_t t;
        int phase_no;
        int r;
        int pw;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // power-up timing
        push_tick(1'b1, CMD_UNKNOWN, 8'hFF, 1'b1);
        queue_cmd(CMD_READ, 8'h00, 0, 0, 1'b0);
        wait_drained();

        // directed: shortest timing, data extremes, every presence outcome
        program_timing('{reset_low_us: 1, reset_release_us: 0, write_one_low_us: 1,
                         write_zero_low_us: 1, read_low_us: 1, read_sample_us: 0,
                         read_tail_us: 0, presence_wait_us: 2});
        push_tick(1'b0, CMD_RESET, 8'h00, 1'b0);
        queue_cmd(CMD_WRITE, 8'h00, 0, 0, 1'b0);
        queue_cmd(CMD_WRITE, 8'hFF, 0, 0, 1'b0);
        queue_cmd(CMD_READ, 8'h5A, 0, 0, 1'b0);
        queue_cmd(CMD_RESET, 8'h00, 1, 1, 1'b0);
        queue_cmd(CMD_RESET, 8'h00, 0, 0, 1'b0);
        queue_cmd(CMD_RESET, 8'h00, 0, LOW_RUN_LIMIT - 1, 1'b0);
        queue_cmd(CMD_RESET, 8'h00, 1, LOW_RUN_LIMIT, 1'b0);
        queue_cmd(CMD_WRITE, 8'hA5, 0, 0, 1'b1);
        wait_drained();

        // widest read, write and presence timing, one reset only
        program_timing('{reset_low_us: 64, reset_release_us: 0, write_one_low_us: 1023,
                         write_zero_low_us: 1023, read_low_us: 1023,
                         read_sample_us: 1023, read_tail_us: 1023,
                         presence_wait_us: 1023});
        queue_cmd(CMD_RESET, 8'h00, 2, 3, 1'b0);
        wait_drained();

        pushed = 0;
        phase_no = 0;
        while (pushed < 450) begin
            t.reset_low_us = CFG_W'($urandom_range(1, 8));
            t.reset_release_us = CFG_W'($urandom_range(0, 4));
            t.write_one_low_us = CFG_W'($urandom_range(1, 4));
            t.write_zero_low_us = CFG_W'($urandom_range(1, 6));
            t.read_low_us = CFG_W'($urandom_range(1, 3));
            t.read_sample_us = CFG_W'($urandom_range(0, 3));
            t.read_tail_us = CFG_W'($urandom_range(0, 4));
            t.presence_wait_us = CFG_W'($urandom_range(1, 10));
            program_timing(t);
            calm = (phase_no == 1);
            pw = span_of(timing.presence_wait_us);
            repeat ($urandom_range(3, 6)) begin
                r = $urandom_range(99);
                if (r < 40)
                    queue_cmd(CMD_WRITE, 8'($urandom), 0, 0, $urandom_range(9) == 0);
                else if (r < 75)
                    queue_cmd(CMD_READ, 8'($urandom), 0, 0, $urandom_range(9) == 0);
                else begin
                    r = $urandom_range(99);
                    if (r < 60)
                        queue_cmd(CMD_RESET, 8'($urandom), $urandom_range(0, pw - 1),
                                  ($urandom_range(7) == 0) ? LOW_RUN_LIMIT - 1
                                                           : $urandom_range(1, 6),
                                  $urandom_range(9) == 0);
                    else if (r < 92)
                        queue_cmd(CMD_RESET, 8'($urandom), 0, 0, $urandom_range(9) == 0);
                    else
                        queue_cmd(CMD_RESET, 8'($urandom), $urandom_range(0, pw - 1),
                                  LOW_RUN_LIMIT, 1'b0);
                end
            end
            wait_drained();
            calm = 1'b0;
            phase_no++;
        end

        repeat (10) @(posedge aclk);
        if (bus_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", bus_results.size()));
        if (mism_cnt == 0)
            $display("PASS onewire_bus_master_unit");
        else
            $display("FAIL onewire_bus_master_unit");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL onewire_bus_master_unit");
        $finish;
    end

endmodule

`default_nettype wire
